[rtl/unique_id_handle_table_top_defines.svh]
// ----------------------------------------------------------------------------
// handle table assertion macros
// clocked implication checks shared by the handle table rtl
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ID_HANDLE_TABLE_TOP_DEFINES_SVH
`define UNIQUE_ID_HANDLE_TABLE_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define UIH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define UIH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/uiht_pkg.sv]
// ----------------------------------------------------------------------------
// uiht_pkg
// shared action codes, error codes, table size and sequencer state type
// ----------------------------------------------------------------------------
package uiht_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int AW        = $clog2(MAX_SLOTS);
    localparam int CW        = AW + 1;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_GET    = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_UNUSE  = 3'd4,
        ACT_REUSE  = 3'd5,
        ACT_CLEAR  = 3'd6,
        ACT_BAD    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_UNUSED = 2'd1,
        ERR_RANGE  = 2'd2,
        ERR_SPARE  = 2'd3
    } err_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_DEC  = 8'b00000010,
        ST_RDW  = 8'b00000100,
        ST_SHUP = 8'b00001000,
        ST_BIND = 8'b00010000,
        ST_FREE = 8'b00100000,
        ST_SHDN = 8'b01000000,
        ST_OUT  = 8'b10000000
    } state_t;

endpackage

[rtl/unique_id_handle_table_top.sv]
// steps after acceptance: errors, clear and reuse with nothing unused go straight to the result;
// get, find and unuse read once; reuse reads the empty-slot stack, then binds the slot; insert
// moves the later slots up, then binds the run; delete frees the run, then moves later slots down
// one transaction at a time: in_ready only in idle, the result waits in an output register
// and the next transaction can be accepted in the cycle after the result is taken
// asynchronous active-low reset clears the counters and the sequencer; memories keep data
// ----------------------------------------------------------------------------
// unique_id_handle_table_top
// ordered slot table with unique ids, free-id stack and empty-slot stack
// ----------------------------------------------------------------------------
`include "unique_id_handle_table_top_defines.svh"

module unique_id_handle_table_top #(
    parameter int MAX_RUN = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [8:0] position,
    input  logic [4:0] run_length,
    input  logic [7:0] id_offset,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] slot,
    output logic [7:0] id_out,
    output logic       valid_res,
    output logic       slot_empty_mark,
    output logic [1:0] error
);
    localparam int NS = uiht_pkg::MAX_SLOTS;
    localparam int AW = uiht_pkg::AW;
    localparam int CW = uiht_pkg::CW;

    uiht_pkg::state_t  state_reg, state_next;
    uiht_pkg::action_t act_reg;

    logic [AW:0]   s2i_mem [NS];   // {unused mark, id}
    logic [AW:0]   i2s_mem [NS];   // {bound, slot}
    logic [AW-1:0] fid_mem [NS];
    logic [AW-1:0] es_mem  [NS];

    logic [CW-1:0] fcnt_reg, ecnt_reg, scnt_reg, iss_reg;
    logic [CW-1:0] pos_reg, n_reg, i_reg, k_reg;
    logic [7:0]    idq_reg;
    logic          ph_reg;   // two-phase step: read then write

    logic [7:0] r_slot_reg, r_id_reg;
    logic       r_val_reg, r_mark_reg;
    logic [1:0] r_err_reg;

    // memory ports, driven by the sequencer
    logic          s2i_we, i2s_we, fid_we, es_we;
    logic [AW-1:0] s2i_wa, s2i_ra, i2s_wa, i2s_ra, fid_wa, fid_ra, es_wa, es_ra;
    logic [AW:0]   s2i_wd, i2s_wd, s2i_q, i2s_q;
    logic [AW-1:0] fid_wd, es_wd, fid_q, es_q;

    logic [CW:0]   pos_n, sc_n;
    logic [AW-1:0] pos_a, bind_id;
    logic          have_free, have_fresh, bind_ok, bad_n;
    logic [1:0]    dec_err;

    always_ff @(posedge clk)
    begin
        if (s2i_we) s2i_mem[s2i_wa] <= s2i_wd;
        if (i2s_we) i2s_mem[i2s_wa] <= i2s_wd;
        if (fid_we) fid_mem[fid_wa] <= fid_wd;
        if (es_we)  es_mem[es_wa]   <= es_wd;
        s2i_q <= s2i_mem[s2i_ra];
        i2s_q <= i2s_mem[i2s_ra];
        fid_q <= fid_mem[fid_ra];
        es_q  <= es_mem[es_ra];
    end

    assign in_ready        = (state_reg == uiht_pkg::ST_IDLE);
    assign out_valid       = (state_reg == uiht_pkg::ST_OUT);
    assign slot            = r_slot_reg;
    assign id_out          = r_id_reg;
    assign valid_res       = r_val_reg;
    assign slot_empty_mark = r_mark_reg;
    assign error           = r_err_reg;

    assign pos_n = {1'b0, pos_reg} + {1'b0, n_reg};
    assign sc_n  = {1'b0, scnt_reg} + {1'b0, n_reg};
    assign pos_a = pos_reg[AW-1:0];
    assign bad_n = (n_reg == '0) || (n_reg > CW'(MAX_RUN));

    // id pick for bind: free stack first, then fresh
    assign have_free  = (fcnt_reg != '0);
    assign have_fresh = (iss_reg < CW'(NS));
    assign bind_id    = have_free ? fid_q : iss_reg[AW-1:0];
    assign bind_ok    = (have_free || have_fresh) &&
                        (({1'b0, pos_reg} + {1'b0, k_reg}) < (CW+1)'(NS));

    always_comb
    begin
        dec_err = uiht_pkg::ERR_OK;
        case (act_reg)
            uiht_pkg::ACT_INSERT:
                if (bad_n || pos_reg > scnt_reg || sc_n > (CW+1)'(NS))
                    dec_err = uiht_pkg::ERR_RANGE;
                else if (pos_reg < scnt_reg && ecnt_reg != '0)
                    dec_err = uiht_pkg::ERR_UNUSED;
            uiht_pkg::ACT_DELETE:
                if (ecnt_reg != '0) dec_err = uiht_pkg::ERR_UNUSED;
                else if (bad_n || pos_n > {1'b0, scnt_reg}) dec_err = uiht_pkg::ERR_RANGE;
            uiht_pkg::ACT_GET:
                if (pos_reg >= scnt_reg) dec_err = uiht_pkg::ERR_RANGE;
            uiht_pkg::ACT_FIND:
                if (CW'(idq_reg) >= iss_reg) dec_err = uiht_pkg::ERR_RANGE;
            uiht_pkg::ACT_UNUSE:
                if (pos_reg >= scnt_reg || ecnt_reg >= CW'(NS))
                    dec_err = uiht_pkg::ERR_RANGE;
            uiht_pkg::ACT_REUSE: ;
            uiht_pkg::ACT_CLEAR: ;
            default: dec_err = uiht_pkg::ERR_RANGE;
        endcase
    end

    always_comb
    begin
        s2i_we = 1'b0; i2s_we = 1'b0; fid_we = 1'b0; es_we = 1'b0;
        s2i_ra = pos_a;
        i2s_ra = AW'(idq_reg);
        fid_ra = AW'(fcnt_reg - CW'(1));
        es_ra  = AW'(ecnt_reg - CW'(1));
        s2i_wa = '0; s2i_wd = '0; i2s_wa = '0; i2s_wd = '0;
        fid_wa = fcnt_reg[AW-1:0]; fid_wd = '0;
        es_wa  = ecnt_reg[AW-1:0]; es_wd  = pos_a;
        case (state_reg)
            uiht_pkg::ST_RDW:
                // unuse: free the id, mark the slot and push it
                if (act_reg == uiht_pkg::ACT_UNUSE && r_err_reg == uiht_pkg::ERR_OK &&
                    !s2i_q[AW])
                begin
                    s2i_wa = pos_a;
                    s2i_wd = {1'b1, {AW{1'b0}}};
                    s2i_we = 1'b1;
                    i2s_wa = s2i_q[AW-1:0];
                    i2s_we = 1'b1;
                    fid_wd = s2i_q[AW-1:0];
                    fid_we = (fcnt_reg < CW'(NS));
                    es_we  = 1'b1;
                end
            uiht_pkg::ST_SHUP:
            begin
                s2i_ra = AW'(i_reg - CW'(1));
                s2i_wa = AW'(i_reg - CW'(1) + n_reg);
                s2i_wd = s2i_q;
                s2i_we = ph_reg;
                i2s_wa = s2i_q[AW-1:0];
                i2s_wd = {1'b1, AW'(i_reg - CW'(1) + n_reg)};
                i2s_we = ph_reg && !s2i_q[AW];
            end
            uiht_pkg::ST_BIND:
            begin
                s2i_wa = AW'(pos_reg + k_reg);
                s2i_wd = {1'b0, bind_id};
                s2i_we = ph_reg && bind_ok;
                i2s_wa = bind_id;
                i2s_wd = {1'b1, AW'(pos_reg + k_reg)};
                i2s_we = ph_reg && bind_ok;
            end
            uiht_pkg::ST_FREE:
            begin
                s2i_ra = AW'(pos_reg + k_reg);
                fid_wd = s2i_q[AW-1:0];
                fid_we = ph_reg && (fcnt_reg < CW'(NS));
                i2s_wa = s2i_q[AW-1:0];
                i2s_we = ph_reg;
            end
            uiht_pkg::ST_SHDN:
            begin
                s2i_ra = i_reg[AW-1:0];
                s2i_wa = AW'(i_reg - n_reg);
                s2i_wd = s2i_q;
                s2i_we = ph_reg;
                i2s_wa = s2i_q[AW-1:0];
                i2s_wd = {1'b1, AW'(i_reg - n_reg)};
                i2s_we = ph_reg && !s2i_q[AW];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uiht_pkg::ST_IDLE:
                if (in_valid) state_next = uiht_pkg::ST_DEC;
            uiht_pkg::ST_DEC:
                if (dec_err != uiht_pkg::ERR_OK) state_next = uiht_pkg::ST_OUT;
                else
                    case (act_reg)
                        uiht_pkg::ACT_INSERT:
                            state_next = (pos_reg < scnt_reg) ? uiht_pkg::ST_SHUP
                                                              : uiht_pkg::ST_BIND;
                        uiht_pkg::ACT_DELETE: state_next = uiht_pkg::ST_FREE;
                        uiht_pkg::ACT_GET:    state_next = uiht_pkg::ST_RDW;
                        uiht_pkg::ACT_FIND:   state_next = uiht_pkg::ST_RDW;
                        uiht_pkg::ACT_UNUSE:  state_next = uiht_pkg::ST_RDW;
                        uiht_pkg::ACT_REUSE:
                            state_next = (ecnt_reg != '0) ? uiht_pkg::ST_RDW
                                                          : uiht_pkg::ST_OUT;
                        default:              state_next = uiht_pkg::ST_OUT;
                    endcase
            uiht_pkg::ST_RDW:
                state_next = (act_reg == uiht_pkg::ACT_REUSE) ? uiht_pkg::ST_BIND
                                                              : uiht_pkg::ST_OUT;
            uiht_pkg::ST_SHUP:
                if (ph_reg && (i_reg - CW'(1) <= pos_reg)) state_next = uiht_pkg::ST_BIND;
            uiht_pkg::ST_BIND:
                if (ph_reg && (k_reg + CW'(1) >= n_reg)) state_next = uiht_pkg::ST_OUT;
            uiht_pkg::ST_FREE:
                if (ph_reg && (k_reg + CW'(1) >= n_reg))
                    state_next = (pos_n[CW-1:0] < scnt_reg) ? uiht_pkg::ST_SHDN
                                                             : uiht_pkg::ST_OUT;
            uiht_pkg::ST_SHDN:
                if (ph_reg && (i_reg + CW'(1) >= scnt_reg)) state_next = uiht_pkg::ST_OUT;
            uiht_pkg::ST_OUT:
                if (out_ready) state_next = uiht_pkg::ST_IDLE;
            default: state_next = uiht_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= uiht_pkg::ST_IDLE;
            act_reg    <= uiht_pkg::ACT_INSERT;
            fcnt_reg   <= '0;
            ecnt_reg   <= '0;
            scnt_reg   <= '0;
            iss_reg    <= '0;
            pos_reg    <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            idq_reg    <= '0;
            ph_reg     <= 1'b0;
            r_slot_reg <= '0;
            r_id_reg   <= '0;
            r_val_reg  <= 1'b0;
            r_mark_reg <= 1'b0;
            r_err_reg  <= uiht_pkg::ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= (state_next == state_reg) ? ~ph_reg : 1'b0;
            case (state_reg)
                uiht_pkg::ST_IDLE:
                    if (in_valid)
                    begin
                        act_reg    <= uiht_pkg::action_t'(action);
                        pos_reg    <= CW'(position);
                        n_reg      <= CW'(run_length);
                        idq_reg    <= id_offset;
                        r_slot_reg <= '0;
                        r_id_reg   <= '0;
                        r_val_reg  <= 1'b0;
                        r_mark_reg <= 1'b0;
                        r_err_reg  <= uiht_pkg::ERR_OK;
                        k_reg      <= '0;
                        i_reg      <= '0;
                    end
                uiht_pkg::ST_DEC:
                begin
                    r_err_reg <= dec_err;
                    if (dec_err == uiht_pkg::ERR_OK)
                        case (act_reg)
                            uiht_pkg::ACT_INSERT:
                            begin
                                r_slot_reg <= 8'(pos_reg);
                                r_val_reg  <= 1'b1;
                                scnt_reg   <= sc_n[CW-1:0];
                                i_reg      <= scnt_reg;
                            end
                            uiht_pkg::ACT_DELETE: i_reg <= pos_n[CW-1:0];
                            uiht_pkg::ACT_REUSE:
                                if (ecnt_reg != '0) ecnt_reg <= ecnt_reg - CW'(1);
                            uiht_pkg::ACT_CLEAR:
                            begin
                                fcnt_reg <= '0;
                                ecnt_reg <= '0;
                                scnt_reg <= '0;
                                iss_reg  <= '0;
                            end
                            default: ;
                        endcase
                end
                uiht_pkg::ST_RDW:
                    // read data of get, find, unuse and reuse is valid here
                    case (act_reg)
                        uiht_pkg::ACT_GET:
                            if (s2i_q[AW]) r_mark_reg <= 1'b1;
                            else
                            begin
                                r_id_reg  <= s2i_q[AW-1:0];
                                r_val_reg <= 1'b1;
                            end
                        uiht_pkg::ACT_FIND:
                            if (i2s_q[AW])
                            begin
                                r_slot_reg <= i2s_q[AW-1:0];
                                r_val_reg  <= 1'b1;
                            end
                        uiht_pkg::ACT_UNUSE:
                            if (s2i_q[AW]) r_err_reg <= uiht_pkg::ERR_RANGE;
                            else
                            begin
                                if (fid_we) fcnt_reg <= fcnt_reg + CW'(1);
                                ecnt_reg <= ecnt_reg + CW'(1);
                            end
                        uiht_pkg::ACT_REUSE:
                        begin
                            pos_reg    <= CW'(es_q);
                            r_slot_reg <= es_q;
                            r_val_reg  <= 1'b1;
                            n_reg      <= CW'(1);
                            k_reg      <= '0;
                        end
                        default: ;
                    endcase
                uiht_pkg::ST_SHUP:
                    if (ph_reg) i_reg <= i_reg - CW'(1);
                uiht_pkg::ST_BIND:
                    if (ph_reg)
                    begin
                        k_reg <= k_reg + CW'(1);
                        if (bind_ok)
                        begin
                            if (have_free) fcnt_reg <= fcnt_reg - CW'(1);
                            else iss_reg <= iss_reg + CW'(1);
                        end
                    end
                uiht_pkg::ST_FREE:
                    if (ph_reg)
                    begin
                        k_reg <= k_reg + CW'(1);
                        if (fid_we) fcnt_reg <= fcnt_reg + CW'(1);
                        if (state_next == uiht_pkg::ST_OUT) scnt_reg <= scnt_reg - n_reg;
                    end
                uiht_pkg::ST_SHDN:
                    if (ph_reg)
                    begin
                        i_reg <= i_reg + CW'(1);
                        if (state_next == uiht_pkg::ST_OUT) scnt_reg <= scnt_reg - n_reg;
                    end
                default: ;
            endcase
        end
    end

    `UIH_ASSERT_IMP(a_one_side, out_valid, !in_ready, "input taken while result pending")
    `UIH_ASSERT_IMP(a_cnt_cap, 1'b1, scnt_reg <= CW'(NS), "slot count over capacity")
    `UIH_ASSERT_IMP(a_empty_le, 1'b1, ecnt_reg <= scnt_reg, "more empty slots than slots")
    `UIH_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(slot),
                    "result dropped before taken")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// handle table testbench
// drives actions through the valid/ready input channel, predicts each result
// with a behavioral copy of the table and checks every result field by field
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 256;
    localparam int NRUN  = 16;

    typedef struct packed {
        logic [7:0] slot;
        logic [7:0] id_out;
        logic       valid_res;
        logic       mark;
        logic [1:0] error;
    } table_res_t;

    // behavioral handle table plus queue of predicted results
    class table_scoreboard;
        int unsigned slot_id[NSLOT];
        bit          slot_mk[NSLOT];
        int unsigned id_slot[NSLOT];
        bit          id_bnd[NSLOT];
        int unsigned free_ids[NSLOT];
        int unsigned free_cnt;
        int unsigned empty_slots[NSLOT];
        int unsigned empty_cnt;
        int unsigned count;
        int unsigned issued;
        table_res_t  pending[$];
        int          errors;
        int          checked;

        function void wipe();
            free_cnt = 0;
            empty_cnt = 0;
            count = 0;
            issued = 0;
            foreach (id_bnd[i]) id_bnd[i] = 0;
            foreach (slot_mk[i]) slot_mk[i] = 0;
        endfunction

        function void bind_run(int unsigned p, int unsigned n);
            int unsigned s;
            int unsigned id;
            for (int unsigned k = 0; k < n; k++)
            begin
                s = p + k;
                if (s >= NSLOT) return;
                if (free_cnt > 0)
                begin
                    free_cnt--;
                    id = free_ids[free_cnt];
                end
                else
                begin
                    if (issued >= NSLOT) return;
                    id = issued++;
                end
                slot_id[s] = id;
                slot_mk[s] = 0;
                id_slot[id] = s;
                id_bnd[id] = 1;
            end
        endfunction

        function void release_id(int unsigned id);
            if (id < NSLOT)
            begin
                id_bnd[id] = 0;
                if (free_cnt < NSLOT) free_ids[free_cnt++] = id;
            end
        endfunction

        function void note_input(uiht_pkg::action_t act, int unsigned p, int unsigned n,
                                 int unsigned q);
            table_res_t r;
            int unsigned id;
            r = '0;
            case (act)
                uiht_pkg::ACT_INSERT:
                begin
                    if (n == 0 || n > NRUN || p > count || count + n > NSLOT)
                        r.error = uiht_pkg::ERR_RANGE;
                    else if (p < count && empty_cnt > 0)
                        r.error = uiht_pkg::ERR_UNUSED;
                    else
                    begin
                        if (p < count)
                        begin
                            for (int unsigned i = 0; i < issued; i++)
                                if (id_bnd[i] && id_slot[i] >= p) id_slot[i] += n;
                            for (int unsigned i = count; i > p; i--)
                            begin
                                slot_id[i - 1 + n] = slot_id[i - 1];
                                slot_mk[i - 1 + n] = slot_mk[i - 1];
                            end
                        end
                        count += n;
                        bind_run(p, n);
                        r.slot = p[7:0];
                        r.valid_res = 1;
                    end
                end
                uiht_pkg::ACT_DELETE:
                begin
                    if (empty_cnt > 0)
                        r.error = uiht_pkg::ERR_UNUSED;
                    else if (n == 0 || n > NRUN || p + n > count)
                        r.error = uiht_pkg::ERR_RANGE;
                    else
                    begin
                        for (int unsigned i = p; i < p + n; i++) release_id(slot_id[i]);
                        for (int unsigned i = p + n; i < count; i++)
                        begin
                            id = slot_id[i];
                            if (id < NSLOT) id_slot[id] -= n;
                            slot_id[i - n] = id;
                            slot_mk[i - n] = slot_mk[i];
                        end
                        count -= n;
                    end
                end
                uiht_pkg::ACT_GET:
                begin
                    if (p >= count) r.error = uiht_pkg::ERR_RANGE;
                    else if (slot_mk[p]) r.mark = 1;
                    else
                    begin
                        r.id_out = slot_id[p][7:0];
                        r.valid_res = 1;
                    end
                end
                uiht_pkg::ACT_FIND:
                begin
                    if (q >= issued) r.error = uiht_pkg::ERR_RANGE;
                    else if (id_bnd[q])
                    begin
                        r.slot = id_slot[q][7:0];
                        r.valid_res = 1;
                    end
                end
                uiht_pkg::ACT_UNUSE:
                begin
                    if (p >= count || slot_mk[p] || empty_cnt >= NSLOT)
                        r.error = uiht_pkg::ERR_RANGE;
                    else
                    begin
                        release_id(slot_id[p]);
                        slot_mk[p] = 1;
                        slot_id[p] = 0;
                        empty_slots[empty_cnt++] = p;
                    end
                end
                uiht_pkg::ACT_REUSE:
                begin
                    if (empty_cnt > 0)
                    begin
                        empty_cnt--;
                        r.slot = empty_slots[empty_cnt][7:0];
                        bind_run(empty_slots[empty_cnt], 1);
                        r.valid_res = 1;
                    end
                end
                uiht_pkg::ACT_CLEAR: wipe();
                default: r.error = uiht_pkg::ERR_RANGE;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(table_res_t got);
            table_res_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.slot !== e.slot)
            begin
                $error("slot: expected %0d actual %0d", e.slot, got.slot);
                errors++;
            end
            if (got.id_out !== e.id_out)
            begin
                $error("id_out: expected %0d actual %0d", e.id_out, got.id_out);
                errors++;
            end
            if (got.valid_res !== e.valid_res)
            begin
                $error("valid_res: expected %0d actual %0d", e.valid_res, got.valid_res);
                errors++;
            end
            if (got.mark !== e.mark)
            begin
                $error("slot_empty_mark: expected %0d actual %0d", e.mark, got.mark);
                errors++;
            end
            if (got.error !== e.error)
            begin
                $error("error: expected %0d actual %0d", e.error, got.error);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [8:0] position;
    logic [4:0] run_length;
    logic [7:0] id_offset;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] slot;
    logic [7:0] id_out;
    logic       valid_res;
    logic       slot_empty_mark;
    logic [1:0] error;

    table_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int sent;

    unique_id_handle_table_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .position(position), .run_length(run_length),
        .id_offset(id_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .slot(slot), .id_out(id_out), .valid_res(valid_res),
        .slot_empty_mark(slot_empty_mark), .error(error)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    // result side: random stall, checks at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{slot, id_out, valid_res, slot_empty_mark, error});
    end

    always @(negedge clk)
    begin
        if (!rst_n) out_ready <= 0;
        else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_op(uiht_pkg::action_t act, int unsigned p, int unsigned n,
                           int unsigned q);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid   <= 1;
        action     <= act;
        position   <= p[8:0];
        run_length <= n[4:0];
        id_offset  <= q[7:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(act, p, n, q);
        sent++;
        @(negedge clk);
        in_valid <= 0;
    endtask

    // mostly well-formed operations aimed at the live table
    task automatic random_op();
        int unsigned w;
        int unsigned cnt;
        uiht_pkg::action_t act;
        w = $urandom_range(99);
        cnt = sb.count;
        if (w < 3)
            send_op(uiht_pkg::action_t'($urandom_range(7)), $urandom_range(511),
                    $urandom_range(31), $urandom_range(255));
        else if (w < 28)
        begin
            if (sb.empty_cnt > 0 && $urandom_range(3) != 0)
                send_op(uiht_pkg::ACT_INSERT, cnt, $urandom_range(1, NRUN), 0);
            else
                send_op(uiht_pkg::ACT_INSERT, $urandom_range(cnt), $urandom_range(1, 8),
                        $urandom_range(255));
        end
        else if (w < 45)
        begin
            if (sb.empty_cnt > 0)
                send_op(uiht_pkg::ACT_REUSE, 0, 1, 0);
            else
                send_op(uiht_pkg::ACT_DELETE, $urandom_range(cnt), $urandom_range(1, 8), 0);
        end
        else if (w < 62)
            send_op(uiht_pkg::ACT_GET, $urandom_range(cnt), 1, 0);
        else if (w < 79)
            send_op(uiht_pkg::ACT_FIND, 0, 1, $urandom_range(sb.issued));
        else if (w < 89)
            send_op(uiht_pkg::ACT_UNUSE, $urandom_range(cnt), 1, 0);
        else if (w < 98)
            send_op(uiht_pkg::ACT_REUSE, 0, 1, 0);
        else
        begin
            act = (cnt > 200) ? uiht_pkg::ACT_CLEAR : uiht_pkg::ACT_GET;
            send_op(act, 0, 1, 0);
        end
    endtask

    initial
    begin
        sb = new();
        sb.wipe();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 0;
        in_valid = 0;
        action = uiht_pkg::ACT_CLEAR;
        position = 0;
        run_length = 0;
        id_offset = 0;
        out_ready = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed corners
        send_op(uiht_pkg::ACT_FIND, 0, 1, 0);
        send_op(uiht_pkg::ACT_GET, 0, 1, 0);
        send_op(uiht_pkg::ACT_INSERT, 0, 0, 0);
        send_op(uiht_pkg::ACT_INSERT, 0, 17, 0);
        send_op(uiht_pkg::ACT_INSERT, 1, 4, 0);
        send_op(uiht_pkg::ACT_INSERT, 0, NRUN, 255);
        send_op(uiht_pkg::ACT_INSERT, 4, 3, 0);
        send_op(uiht_pkg::ACT_DELETE, 2, 3, 0);
        send_op(uiht_pkg::ACT_INSERT, 0, 2, 0);
        send_op(uiht_pkg::ACT_FIND, 0, 1, 3);
        send_op(uiht_pkg::ACT_FIND, 0, 1, 255);
        send_op(uiht_pkg::ACT_DELETE, 10, 31, 0);
        send_op(uiht_pkg::ACT_UNUSE, 5, 1, 0);
        send_op(uiht_pkg::ACT_UNUSE, 5, 1, 0);
        send_op(uiht_pkg::ACT_GET, 5, 1, 0);
        send_op(uiht_pkg::ACT_INSERT, 1, 1, 0);
        send_op(uiht_pkg::ACT_DELETE, 0, 1, 0);
        send_op(uiht_pkg::ACT_INSERT, sb.count, 1, 0);
        send_op(uiht_pkg::ACT_REUSE, 0, 1, 0);
        send_op(uiht_pkg::ACT_REUSE, 0, 1, 0);
        send_op(uiht_pkg::ACT_BAD, 511, 31, 255);
        send_op(uiht_pkg::ACT_GET, 511, 1, 0);
        while (sb.count + NRUN <= NSLOT) send_op(uiht_pkg::ACT_INSERT, sb.count, NRUN, 0);
        send_op(uiht_pkg::ACT_INSERT, sb.count, NRUN, 0);
        send_op(uiht_pkg::ACT_GET, 255, 1, 0);
        send_op(uiht_pkg::ACT_CLEAR, 0, 1, 0);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: begin send_idle_pct = 65; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 65; end
                3: begin send_idle_pct = 33; recv_stall_pct = 33; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (370) random_op();
        end

        send_idle_pct = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        $display("covered %0d transactions, %0d results checked, all actions and corners",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
